// File: design/csp_pkg.sv
package csp_pkg;

    localparam int CSP_POINTS = 16;
    localparam int HW         = 38;
    localparam logic [4:0]  COUNT_RESET = 5'd2;
    localparam logic [16:0] U_ONE       = 17'd65536;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [16:0]        param_t;
    } csp_in_t;

    typedef struct packed {
        logic signed [31:0] curve_x;
        logic signed [31:0] curve_y;
        logic               saturated;
    } csp_out_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // h*u rounded half up back to Q16.16, plus the next coefficient
    function automatic logic signed [HW-1:0] horner_step(
        input logic signed [HW-1:0] h,
        input logic [16:0]          u,
        input logic signed [HW-1:0] c
    );
        logic signed [HW+17:0] prod;
        logic signed [HW+17:0] rnd;
        prod = h * $signed({1'b0, u});
        rnd  = (prod + (HW+18)'(32768)) >>> 16;
        return rnd[HW-1:0] + c;
    endfunction

    function automatic logic signed [HW-1:0] sx(input logic [31:0] v);
        return {{(HW-32){v[31]}}, v};
    endfunction

endpackage

// File: design/csp_ram.sv
module csp_ram #(
    parameter int W = 64,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr_a,
    input  logic [$clog2(D)-1:0] raddr_b,
    output logic [W-1:0]         rdata_a,
    output logic [W-1:0]         rdata_b
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

// File: design/catmull_rom_spline_point_top.sv
// Uniform Catmull-Rom curve point evaluator. Load words (cmd 0) write one 2-D
// control point into the point store; evaluate words (cmd 1) return one curve
// point in signed Q16.16 for the global parameter param_t, with the end
// neighbours clamped and the result saturated to 32 bits (saturated flags it).
// One word is taken every clock while in_stall is low. An evaluate word passes
// through the point store read, done on the edge that takes it, then the
// coefficient stage, three Horner multiply stages and the output register. The
// store is held twice, so that the four neighbouring points are read in the
// same cycle. The user must write point_count through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block does not enforce this. Points must be
// written before an evaluation reads them.
module catmull_rom_spline_point_top #(
    parameter int POINTS = csp_pkg::CSP_POINTS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [4:0]       cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  csp_pkg::csp_in_t in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output csp_pkg::csp_out_t out_word
);
    import csp_pkg::*;

    localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CW = ($clog2(POINTS + 1) > 5) ? $clog2(POINTS + 1) : 5;

    logic [4:0] point_count_reg;

    // stage valids and readiness, stage 1 is the store read
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    logic [16:0] u1_reg, u2_reg, u3_reg, u4_reg;
    logic signed [HW-1:0] ax_reg, bx_reg, cx_reg, dx_reg;
    logic signed [HW-1:0] ay_reg, by_reg, cy_reg, dy_reg;
    logic signed [HW-1:0] c3x_reg, d3x_reg, c3y_reg, d3y_reg;
    logic signed [HW-1:0] d4x_reg, d4y_reg;
    logic signed [HW-1:0] h1x_reg, h1y_reg, h2x_reg, h2y_reg, h3x_reg, h3y_reg;
    csp_out_t out_reg;

    // ---------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            point_count_reg <= cfg_wr_data;
        end
    end

    // ---------------- readiness chain: a stage may load when it is empty or
    // its own word moves on this cycle
    assign rdy6     = !v6_reg || !out_stall;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    logic accept;
    assign accept = in_valid && rdy1;

    // ---------------- segment and neighbour indices
    logic [CW-1:0]    cnt;
    logic [AW-1:0]    n;
    logic [16:0]      t;
    logic [AW+16:0]   tn;
    logic [AW:0]      seg_raw;
    logic [AW-1:0]    seg;
    logic [16:0]      u;
    logic [AW-1:0]    i0, i1, i2, i3;
    logic [AW:0]      seg2;

    always_comb
    begin
        cnt = CW'(point_count_reg);
        if (cnt < CW'(2))
        begin
            cnt = CW'(2);
        end
        if (cnt > CW'(POINTS))
        begin
            cnt = CW'(POINTS);
        end
        n  = AW'(cnt - CW'(1));
        t  = (in_word.param_t > U_ONE) ? U_ONE : in_word.param_t;
        tn = (AW+17)'(t) * (AW+17)'(n);
        seg_raw = tn[AW+16:16];
        if (seg_raw >= (AW+1)'(n))
        begin
            seg = n - AW'(1);
            u   = U_ONE;
        end
        else
        begin
            seg = seg_raw[AW-1:0];
            u   = {1'b0, tn[15:0]};
        end
        i0   = (seg != '0) ? seg - AW'(1) : '0;
        i1   = seg;
        i2   = seg + AW'(1);
        seg2 = (AW+1)'(seg) + (AW+1)'(2);
        i3   = (seg2 <= (AW+1)'(n)) ? seg2[AW-1:0] : n;
    end

    // ---------------- point store, duplicated for four reads a cycle
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [63:0]   st_wdata;
    logic [63:0]   q0, q1, q2, q3;

    assign st_we    = accept && (in_word.cmd == CMD_LOAD)
                      && ((CW+4)'(in_word.point_index) < (CW+4)'(POINTS));
    assign st_waddr = AW'(in_word.point_index);
    assign st_wdata = {in_word.point_y, in_word.point_x};

    csp_ram #(.W(64), .D(POINTS)) u_ram_lo (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (st_wdata),
        .re      (rdy1),
        .raddr_a (i0),
        .raddr_b (i1),
        .rdata_a (q0),
        .rdata_b (q1)
    );

    csp_ram #(.W(64), .D(POINTS)) u_ram_hi (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (st_wdata),
        .re      (rdy1),
        .raddr_a (i2),
        .raddr_b (i3),
        .rdata_a (q2),
        .rdata_b (q3)
    );

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= accept && (in_word.cmd == CMD_EVAL);
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // ---------------- coefficients from the fetched points
    logic signed [HW-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
    assign x0 = sx(q0[31:0]);
    assign x1 = sx(q1[31:0]);
    assign x2 = sx(q2[31:0]);
    assign x3 = sx(q3[31:0]);
    assign y0 = sx(q0[63:32]);
    assign y1 = sx(q1[63:32]);
    assign y2 = sx(q2[63:32]);
    assign y3 = sx(q3[63:32]);

    // ---------------- final halving and clip
    logic signed [HW-1:0] fx, fy;
    logic                 ovx, ovy;
    assign fx  = (h3x_reg + HW'(1)) >>> 1;
    assign fy  = (h3y_reg + HW'(1)) >>> 1;
    assign ovx = (fx[HW-1:31] != '0) && (fx[HW-1:31] != '1);
    assign ovy = (fy[HW-1:31] != '0) && (fy[HW-1:31] != '1);

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            u1_reg <= u;
        end
        if (rdy2)
        begin
            u2_reg <= u1_reg;
            ax_reg <= -x0 + (x1 <<< 1) + x1 - (x2 <<< 1) - x2 + x3;
            bx_reg <= (x0 <<< 1) - (x1 <<< 2) - x1 + (x2 <<< 2) - x3;
            cx_reg <= x2 - x0;
            dx_reg <= x1 <<< 1;
            ay_reg <= -y0 + (y1 <<< 1) + y1 - (y2 <<< 1) - y2 + y3;
            by_reg <= (y0 <<< 1) - (y1 <<< 2) - y1 + (y2 <<< 2) - y3;
            cy_reg <= y2 - y0;
            dy_reg <= y1 <<< 1;
        end
        if (rdy3)
        begin
            u3_reg  <= u2_reg;
            h1x_reg <= horner_step(ax_reg, u2_reg, bx_reg);
            h1y_reg <= horner_step(ay_reg, u2_reg, by_reg);
            c3x_reg <= cx_reg;
            d3x_reg <= dx_reg;
            c3y_reg <= cy_reg;
            d3y_reg <= dy_reg;
        end
        if (rdy4)
        begin
            u4_reg  <= u3_reg;
            h2x_reg <= horner_step(h1x_reg, u3_reg, c3x_reg);
            h2y_reg <= horner_step(h1y_reg, u3_reg, c3y_reg);
            d4x_reg <= d3x_reg;
            d4y_reg <= d3y_reg;
        end
        if (rdy5)
        begin
            h3x_reg <= horner_step(h2x_reg, u4_reg, d4x_reg);
            h3y_reg <= horner_step(h2y_reg, u4_reg, d4y_reg);
        end
        if (rdy6)
        begin
            // clip each coordinate to the signed 32-bit range
            out_reg.curve_x   <= ovx ? (fx[HW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                     : fx[31:0];
            out_reg.curve_y   <= ovy ? (fy[HW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                     : fy[31:0];
            out_reg.saturated <= ovx || ovy;
        end
    end

    assign out_valid = v6_reg;
    assign out_word  = out_reg;

endmodule
